@@ hw/rtl/mqb_pkg.sv @@
// Shared types and codes for the message queue bank.
// Used by the front end, the back end and the top level; no dependencies.
`timescale 1ns / 1ps

package mqb_pkg;

  // Operation codes carried in the op field of an input beat.
  typedef enum logic [1:0] {
    OP_CLAIM = 2'd0,
    OP_SEND  = 2'd1,
    OP_RECV  = 2'd2
  } op_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD_ID  = 3'd1,
    ST_FULL    = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_NO_FREE = 3'd4
  } status_e;

  // Command class decided by the front end.
  typedef enum logic [1:0] {
    CMD_CLAIM,
    CMD_SEND,
    CMD_RECV,
    CMD_BAD
  } cmd_kind_e;

  localparam int QidBits  = 5;
  localparam int TypeBits = 32;
  localparam int WordBits = 64;

  // One classified command as it travels from the front end to the back end.
  typedef struct packed {
    cmd_kind_e             kind;
    logic [QidBits-1:0]    qid;
    logic [TypeBits-1:0]   msg_type;
    logic [WordBits-1:0]   payload;
  } cmd_t;

endpackage

@@ hw/rtl/mqb_ram.sv @@
// Generic single-port RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module mqb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] addr_i,
  input  logic [Width-1:0]                       wdata_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write on we, otherwise read into the output register; data holds between reads.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/mqb_front.sv @@
// Front end of the message queue bank: takes input beats, decodes and checks
// them, and holds the classified commands in a two-entry queue. Uses mqb_pkg.
`timescale 1ns / 1ps

module mqb_front #(
  parameter int NUM_QUEUES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    op_i,
  input  logic [4:0]    queue_id_i,
  input  logic [31:0]   msg_type_i,
  input  logic [63:0]   msg_payload_i,
  output logic          cmd_valid_o,
  input  logic          cmd_pop_i,
  output mqb_pkg::cmd_t cmd_o
);

  import mqb_pkg::*;

  localparam int IdCmpBits = 7;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push;
  logic       id_ok;
  cmd_t       cmd_new;

  // A send or receive target is valid from 1 up to the number of queues.
  assign id_ok = (queue_id_i != '0) &&
                 ({2'b00, queue_id_i} <= IdCmpBits'(NUM_QUEUES));

  // Classify the beat.
  always_comb begin
    cmd_new          = '0;
    cmd_new.qid      = queue_id_i;
    cmd_new.msg_type = msg_type_i;
    cmd_new.payload  = msg_payload_i;
    case (op_i)
      OP_CLAIM: cmd_new.kind = CMD_CLAIM;
      OP_SEND:  cmd_new.kind = id_ok ? CMD_SEND : CMD_BAD;
      OP_RECV:  cmd_new.kind = id_ok ? CMD_RECV : CMD_BAD;
      default:  cmd_new.kind = CMD_BAD;
    endcase
  end

  assign in_ready_o  = (count_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];

  // Queue pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push, cmd_pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

@@ hw/rtl/mqb_back.sv @@
// Back end of the message queue bank: executes commands against the per-queue
// counters and the entry memory, and holds the result register.
// Uses mqb_pkg and mqb_ram.
`timescale 1ns / 1ps

module mqb_back #(
  parameter int NUM_QUEUES   = 16,
  parameter int QUEUE_DEPTH  = 16,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_pop_o,
  input  mqb_pkg::cmd_t cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [2:0]    status_o,
  output logic [4:0]    new_queue_id_o,
  output logic [31:0]   recv_type_o,
  output logic [63:0]   recv_payload_o
);

  import mqb_pkg::*;

  localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int CW    = $clog2(NUM_QUEUES + 1);
  localparam int FW    = $clog2(QUEUE_DEPTH + 1);
  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int NumEntries = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW    = (NumEntries > 1) ? $clog2(NumEntries) : 1;
  localparam int MemW  = TypeBits + PAYLOAD_BITS;

  typedef enum logic {
    S_EXEC,
    S_RESP
  } state_e;

  state_e           state_q;
  logic [FW-1:0]    fill_q [NUM_QUEUES];
  logic [PW-1:0]    head_q [NUM_QUEUES];
  logic [CW-1:0]    claim_cnt_q;
  logic             out_valid_q;
  status_e          resp_status_q;
  logic [4:0]       resp_new_id_q;
  logic             resp_recv_q;
  logic [2:0]       out_status_q;
  logic [4:0]       out_new_id_q;
  logic [31:0]      out_type_q;
  logic [63:0]      out_payload_q;

  logic             exec;
  logic             out_load;
  logic [QW-1:0]    qi;
  logic [FW-1:0]    fill_cur;
  logic [PW-1:0]    head_cur;
  logic [FW:0]      tail_sum;
  logic [PW-1:0]    tail_pos;
  logic [PW-1:0]    head_inc;
  status_e          status_d;
  logic [4:0]       new_id_d;
  logic             recv_ok_d;
  logic             upd_en;
  logic [QW-1:0]    upd_idx;
  logic [FW-1:0]    upd_fill;
  logic [PW-1:0]    upd_head;
  logic             claim_inc;
  logic             mem_en, mem_we;
  logic [AW-1:0]    mem_addr;
  logic [MemW-1:0]  mem_wdata, mem_rdata;

  assign exec      = (state_q == S_EXEC) && cmd_valid_i;
  assign cmd_pop_o = exec;
  assign out_load  = (state_q == S_RESP) && (!out_valid_q || out_ready_i);

  // Look up the target queue's counters and the derived slot positions.
  assign qi       = QW'(cmd_i.qid - 5'd1);
  assign fill_cur = fill_q[qi];
  assign head_cur = head_q[qi];
  assign tail_sum = (FW + 1)'(head_cur) + (FW + 1)'(fill_cur);
  assign tail_pos = (tail_sum >= (FW + 1)'(QUEUE_DEPTH)) ?
                    PW'(tail_sum - (FW + 1)'(QUEUE_DEPTH)) : PW'(tail_sum);
  assign head_inc = (head_cur == PW'(QUEUE_DEPTH - 1)) ? '0 : head_cur + PW'(1);

  assign mem_wdata = {cmd_i.payload[PAYLOAD_BITS-1:0], cmd_i.msg_type};

  // Decide the outcome of the command at the head of the queue.
  always_comb begin
    status_d  = ST_OK;
    new_id_d  = '0;
    recv_ok_d = 1'b0;
    upd_en    = 1'b0;
    upd_idx   = qi;
    upd_fill  = fill_cur;
    upd_head  = head_cur;
    claim_inc = 1'b0;
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = AW'(qi) * AW'(QUEUE_DEPTH) + AW'(head_cur);
    case (cmd_i.kind)
      CMD_CLAIM: begin
        // Queues are never released, so the claimed ones are always the lowest.
        if (claim_cnt_q == CW'(NUM_QUEUES)) begin
          status_d = ST_NO_FREE;
        end else begin
          upd_en    = 1'b1;
          upd_idx   = claim_cnt_q[QW-1:0];
          upd_fill  = '0;
          upd_head  = '0;
          claim_inc = 1'b1;
          new_id_d  = 5'(claim_cnt_q + CW'(1));
        end
      end
      CMD_SEND: begin
        if (fill_cur == FW'(QUEUE_DEPTH)) begin
          status_d = ST_FULL;
        end else begin
          upd_en   = 1'b1;
          upd_fill = fill_cur + FW'(1);
          mem_en   = 1'b1;
          mem_we   = 1'b1;
          mem_addr = AW'(qi) * AW'(QUEUE_DEPTH) + AW'(tail_pos);
        end
      end
      CMD_RECV: begin
        if (fill_cur == '0) begin
          status_d = ST_EMPTY;
        end else begin
          upd_en    = 1'b1;
          upd_fill  = fill_cur - FW'(1);
          upd_head  = head_inc;
          mem_en    = 1'b1;
          recv_ok_d = 1'b1;
        end
      end
      default: status_d = ST_BAD_ID;
    endcase
  end

  mqb_ram #(
    .Width (MemW),
    .Depth (NumEntries)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .en_i    (exec && mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Sequencer, queue counters and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_EXEC;
      claim_cnt_q <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        fill_q[i] <= '0;
        head_q[i] <= '0;
      end
    end else begin
      case (state_q)
        S_EXEC: begin
          if (exec) begin
            state_q <= S_RESP;
            if (upd_en) begin
              fill_q[upd_idx] <= upd_fill;
              head_q[upd_idx] <= upd_head;
            end
            if (claim_inc) begin
              claim_cnt_q <= claim_cnt_q + CW'(1);
            end
          end
        end
        S_RESP: begin
          if (out_load) begin
            state_q <= S_EXEC;
          end
        end
        default: state_q <= S_EXEC;
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Response fields held between execute and the result register.
  always_ff @(posedge clk_i) begin
    if (exec) begin
      resp_status_q <= status_d;
      resp_new_id_q <= new_id_d;
      resp_recv_q   <= recv_ok_d;
    end
    if (out_load) begin
      out_status_q  <= resp_status_q;
      out_new_id_q  <= resp_new_id_q;
      out_type_q    <= resp_recv_q ? mem_rdata[TypeBits-1:0] : '0;
      out_payload_q <= resp_recv_q ? 64'(mem_rdata[MemW-1:TypeBits]) : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign new_queue_id_o = out_new_id_q;
  assign recv_type_o    = out_type_q;
  assign recv_payload_o = out_payload_q;

endmodule

@@ hw/rtl/message_queue_bank.sv @@
// Message queue bank: an accepted input beat waits in the front-end queue, then passes
// the execute/response pair of the back-end sequencer around the registered read of the
// entry memory; the back end takes no new item until the last one's result is loaded.
// Reset empties and unclaims every queue at once; the entry memory is not cleared.
// Depends on mqb_pkg, mqb_front, mqb_back and mqb_ram.
`timescale 1ns / 1ps

module message_queue_bank #(
  parameter int NUM_QUEUES   = 16,
  parameter int QUEUE_DEPTH  = 16,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // op[1:0], queue_id[6:2], key[38:7], msg_type[70:39], msg_payload[134:71], zero pad
  input  logic [135:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // status[2:0], new_queue_id[7:3], recv_type[39:8], recv_payload[103:40]
  output logic [103:0]  m_axis_tdata
);

  import mqb_pkg::*;

  cmd_t        cmd;
  logic        cmd_valid, cmd_pop;
  logic [2:0]  status;
  logic [4:0]  new_queue_id;
  logic [31:0] recv_type;
  logic [63:0] recv_payload;

  // The key has no effect on any result, so it is not kept.
  mqb_front #(
    .NUM_QUEUES (NUM_QUEUES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .op_i          (s_axis_tdata[1:0]),
    .queue_id_i    (s_axis_tdata[6:2]),
    .msg_type_i    (s_axis_tdata[70:39]),
    .msg_payload_i (s_axis_tdata[134:71]),
    .cmd_valid_o   (cmd_valid),
    .cmd_pop_i     (cmd_pop),
    .cmd_o         (cmd)
  );

  mqb_back #(
    .NUM_QUEUES   (NUM_QUEUES),
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_pop_o      (cmd_pop),
    .cmd_i          (cmd),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .status_o       (status),
    .new_queue_id_o (new_queue_id),
    .recv_type_o    (recv_type),
    .recv_payload_o (recv_payload)
  );

  // Pack the result beat.
  assign m_axis_tdata = {recv_payload, recv_type, new_queue_id, status};

endmodule

@@ dv/message_queue_bank_checker.sv @@
// Checker for the message queue bank: watches both stream channels, predicts each reply
// from its own model of the queues and compares every reply beat field by field.
// Depends on mqb_pkg for the operation and status codes.
`timescale 1ns / 1ps

module message_queue_bank_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  // op[1:0], queue_id[6:2], key[38:7], msg_type[70:39], msg_payload[134:71], zero pad
  input  logic [135:0] s_tdata_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  // status[2:0], new_queue_id[7:3], recv_type[39:8], recv_payload[103:40]
  input  logic [103:0] m_tdata_i,
  output int           fail_count_o,
  output int           pending_o
);

  import mqb_pkg::*;

  localparam int NumQueues  = 16;
  localparam int QueueDepth = 16;

  typedef struct packed {
    status_e            status;
    logic [4:0]         new_queue_id;
    logic signed [31:0] recv_type;
    logic [63:0]        recv_payload;
  } reply_t;

  // Model of the queue bank: per-queue counters and the shared entry memory.
  logic        q_claimed [NumQueues];
  logic [4:0]  q_fill [NumQueues];
  logic [3:0]  q_head [NumQueues];
  logic [31:0] slot_type [NumQueues * QueueDepth];
  logic [63:0] slot_payload [NumQueues * QueueDepth];

  reply_t expected_replies [$];
  reply_t oldest;

  // Applies one command beat to the model and returns the reply it must cause.
  function automatic reply_t predict_reply(input logic [135:0] beat);
    reply_t     r;
    logic [1:0] op;
    logic [4:0] qid;
    logic [3:0] q;
    logic [3:0] pos;
    bit         found;
    op    = beat[1:0];
    qid   = beat[6:2];
    q     = 4'(qid - 5'd1);
    r     = '0;
    found = 1'b0;
    r.status = ST_OK;
    case (op)
      OP_CLAIM: begin
        r.status = ST_NO_FREE;
        for (int i = 0; i < NumQueues; i++) begin
          if (!found && !q_claimed[i]) begin
            found          = 1'b1;
            q_claimed[i]   = 1'b1;
            q_fill[i]      = '0;
            q_head[i]      = '0;
            r.status       = ST_OK;
            r.new_queue_id = 5'(i + 1);
          end
        end
      end
      OP_SEND: begin
        if (qid == 5'd0 || qid > 5'(NumQueues)) begin
          r.status = ST_BAD_ID;
        end else if (q_fill[q] >= 5'(QueueDepth)) begin
          r.status = ST_FULL;
        end else begin
          // The head plus the fill wraps around the queue's 16 slots.
          pos = q_head[q] + q_fill[q][3:0];
          slot_type[{q, pos}]    = beat[70:39];
          slot_payload[{q, pos}] = beat[134:71];
          q_fill[q]              = q_fill[q] + 5'd1;
        end
      end
      OP_RECV: begin
        if (qid == 5'd0 || qid > 5'(NumQueues)) begin
          r.status = ST_BAD_ID;
        end else if (q_fill[q] == 5'd0) begin
          r.status = ST_EMPTY;
        end else begin
          r.recv_type    = slot_type[{q, q_head[q]}];
          r.recv_payload = slot_payload[{q, q_head[q]}];
          q_head[q]      = q_head[q] + 4'd1;
          q_fill[q]      = q_fill[q] - 5'd1;
        end
      end
      default: begin
        // The undefined operation changes nothing.
        r.status = ST_BAD_ID;
      end
    endcase
    return r;
  endfunction

  task automatic report_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      fail_count_o++;
      $display("%0t: reply %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // Score reply beats against the oldest prediction, then predict for new command beats.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumQueues; i++) begin
        q_claimed[i] = 1'b0;
        q_fill[i]    = '0;
        q_head[i]    = '0;
      end
      expected_replies.delete();
      fail_count_o = 0;
      pending_o   <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (expected_replies.size() == 0) begin
          fail_count_o++;
          $display("%0t: reply beat with nothing expected, expected none actual %h",
                   $time, m_tdata_i);
        end else begin
          oldest = expected_replies.pop_front();
          report_field("status", 64'(oldest.status), 64'(m_tdata_i[2:0]));
          report_field("new_queue_id", 64'(oldest.new_queue_id), 64'(m_tdata_i[7:3]));
          report_field("recv_type", 64'(oldest.recv_type[31:0]), 64'(m_tdata_i[39:8]));
          report_field("recv_payload", oldest.recv_payload, m_tdata_i[103:40]);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_replies.push_back(predict_reply(s_tdata_i));
      end
      pending_o <= expected_replies.size();
    end
  end

endmodule

@@ dv/tb_message_queue_bank.sv @@
// Testbench top for the message queue bank: drives command beats with random gaps and
// back pressure, and gives the verdict from the checker's failure count.
// Depends on mqb_pkg, message_queue_bank and message_queue_bank_checker.
`timescale 1ns / 1ps

module tb_message_queue_bank;

  import mqb_pkg::*;

  localparam logic [1:0] OpUndef    = 2'd3;
  localparam int         TotalItems = 1770;
  localparam int         DrainWait  = 4;
  localparam int         LongHold   = 300;
  localparam int         CycleLimit = 400000;

  logic         clk;
  logic         rst_n;
  logic         s_tvalid;
  logic         s_tready;
  logic [135:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [103:0] m_tdata;

  int fail_count;
  int pending;
  int items_sent;
  int cycle_count;
  int hold_request;
  bit tx_idle_on;
  bit rx_idle_on;

  message_queue_bank i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  message_queue_bank_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Clock with a 10 ns period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Run limit in case the block stops answering.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("message_queue_bank regression: fail");
      $finish;
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Offers one command beat, after a random gap while transmit idling is on, and waits until it is taken.
  task automatic issue(input logic [1:0] op, input logic [4:0] qid, input logic [31:0] key,
                       input logic [31:0] mtype, input logic [63:0] payload);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, payload, mtype, key, qid, op};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic issue_rand(input logic [1:0] op, input logic [4:0] qid);
    issue(op, qid, $urandom, $urandom, rand_word());
  endtask

  // Stops offering until every predicted reply has arrived, then lets the pipe settle.
  task automatic drain_replies();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  // Reply side: random stalls, plus one long hold-off when requested.
  initial begin
    int gap;
    m_tready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = rx_idle_on ? $urandom_range(0, 4) : 0;
      if (hold_request != 0) begin
        gap          = hold_request;
        hold_request = 0;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Command side: reset, directed cases, then random sequences.
  initial begin
    int         kind;
    int         n;
    int         q0;
    int         pick;
    int         next_drain;
    logic [1:0] op;
    rst_n      = 1'b0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Bad ids at both ends of the range and the undefined operation.
    issue_rand(OP_RECV, 5'd0);
    issue_rand(OP_SEND, 5'd0);
    issue_rand(OP_SEND, 5'd17);
    issue_rand(OP_RECV, 5'd31);
    issue_rand(OpUndef, 5'd1);
    // Empty queue, then extreme types and payloads through queues 1 and 16.
    issue_rand(OP_RECV, 5'd1);
    issue(OP_SEND, 5'd1, 32'h0, 32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(OP_SEND, 5'd1, 32'h0, 32'h7FFF_FFFF, 64'h0);
    issue(OP_SEND, 5'd16, 32'h0, 32'hFFFF_FFFF, 64'h8000_0000_0000_0000);
    issue_rand(OP_RECV, 5'd16);
    issue_rand(OP_RECV, 5'd16);
    // A claim empties queue 1 even though it held entries.
    issue(OP_CLAIM, 5'd0, 32'h0, 32'h0, 64'h0);
    issue_rand(OP_RECV, 5'd1);
    issue(OP_CLAIM, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(OP_SEND, 5'd2, 32'h0, 32'h0, 64'h5555_AAAA_5555_AAAA);
    issue_rand(OP_RECV, 5'd2);
    drain_replies();

    // Long hold-off on the reply side while sends pile up and overflow queue 5.
    tx_idle_on   = 1'b0;
    hold_request = LongHold;
    repeat (20) issue_rand(OP_SEND, 5'd5);
    drain_replies();

    next_drain = items_sent + 400;
    while (items_sent < TotalItems) begin
      kind       = $urandom_range(0, 19);
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if (kind < 10) begin
        // Fill one queue, often past full, then drain it, often past empty.
        q0 = $urandom_range(1, 16);
        n  = $urandom_range(1, 18);
        repeat (n) issue_rand(OP_SEND, 5'(q0));
        n = $urandom_range(1, 18);
        repeat (n) issue_rand(OP_RECV, 5'(q0));
      end else if (kind < 16) begin
        // Sends and receives interleaved over two neighboring queues.
        q0 = $urandom_range(1, 15);
        repeat (16) begin
          op = ($urandom_range(0, 1) != 0) ? OP_SEND : OP_RECV;
          issue_rand(op, 5'(q0 + $urandom_range(0, 1)));
        end
      end else if (kind == 16) begin
        issue_rand(OP_CLAIM, 5'($urandom_range(0, 31)));
      end else begin
        // Noise: any operation on any id.
        repeat (8) begin
          pick = $urandom_range(0, 7);
          if (pick == 0) begin
            op = OP_CLAIM;
          end else if (pick == 1) begin
            op = OpUndef;
          end else if (pick < 5) begin
            op = OP_SEND;
          end else begin
            op = OP_RECV;
          end
          issue_rand(op, 5'($urandom_range(0, 31)));
        end
      end
      if (items_sent >= next_drain) begin
        drain_replies();
        next_drain = items_sent + 400;
      end
    end

    drain_replies();
    if (fail_count == 0) begin
      $display("message_queue_bank regression: pass");
    end else begin
      $display("message_queue_bank regression: fail");
    end
    $finish;
  end

endmodule
